@@ rtl/core/jdc_pkg.sv @@
// ----------------------------------------------------------------------------
// jdc_pkg
// Shared types, constants and tables for the Julian day converter pipeline.
// ----------------------------------------------------------------------------
package jdc_pkg;

  localparam int YEAR_W     = 15;
  localparam int MONTH_W    = 4;
  localparam int DAY_W      = 5;
  localparam int JD_W       = 23;
  localparam int SPAN_W     = 9;   // day offset within a March-based year
  localparam int NUM_STAGES = 6;

  typedef logic signed [YEAR_W-1:0] jdc_year_t;
  typedef logic [MONTH_W-1:0]       jdc_month_t;
  typedef logic [DAY_W-1:0]         jdc_day_t;
  typedef logic [JD_W-1:0]          jdc_jd_t;
  typedef logic [SPAN_W-1:0]        jdc_span_t;
  typedef logic [NUM_STAGES-1:0]    jdc_stage_en_t;

  typedef enum logic {
    REQ_TO_DAY  = 1'b0,
    REQ_TO_DATE = 1'b1
  } jdc_req_e;

  typedef struct packed {
    jdc_stage_en_t en;
    logic          out_valid;
    jdc_req_e      tag;
  } jdc_ctl_t;

  typedef struct packed {
    jdc_jd_t day_number;
    logic    invalid;
  } jdc_day_res_t;

  typedef struct packed {
    jdc_year_t  year;
    jdc_month_t month;
    jdc_day_t   day;
  } jdc_date_res_t;

  // Calendar constants
  localparam int Y_OFS_DAY  = 4800;
  localparam int Y_OFS_CENT = 4900;
  localparam int JD_BIAS    = 32075;
  localparam int L_BIAS     = 68569;
  localparam int CENT       = 100;
  localparam int ERA_DAYS   = 146097;
  localparam int QUAD_DAYS  = 1461;
  localparam int CENT_SCALE = 4000;
  localparam int CENT_CYC   = 1461001;
  localparam int MON_SCALE  = 80;
  localparam int MON_CYC    = 2447;
  localparam int MON_SPAN   = 367;

  // Reciprocal multipliers: floor(x / D) = (x * M) >> S for x below 2**N,
  // with S = N + clog2(D) and M = ceil(2**S / D).
  localparam int DIV100_N  = 15;
  localparam int DIV100_S  = DIV100_N + $clog2(CENT);
  localparam int DIV100_MW = DIV100_N + 1;
  localparam logic [DIV100_MW-1:0] DIV100_M =
    DIV100_MW'(((64'd1 << DIV100_S) + CENT - 1) / CENT);

  localparam int DIVERA_N  = 26;
  localparam int DIVERA_S  = DIVERA_N + $clog2(ERA_DAYS);
  localparam int DIVERA_MW = DIVERA_N + 1;
  localparam logic [DIVERA_MW-1:0] DIVERA_M =
    DIVERA_MW'(((64'd1 << DIVERA_S) + ERA_DAYS - 1) / ERA_DAYS);

  localparam int DIVCYC_N  = 28;
  localparam int DIVCYC_S  = DIVCYC_N + $clog2(CENT_CYC);
  localparam int DIVCYC_MW = DIVCYC_N + 1;
  localparam logic [DIVCYC_MW-1:0] DIVCYC_M =
    DIVCYC_MW'(((64'd1 << DIVCYC_S) + CENT_CYC - 1) / CENT_CYC);

  localparam int DIVMON_N   = 16;
  localparam int DIVMON_S   = DIVMON_N + $clog2(MON_CYC);
  localparam int DIVMON_MW  = DIVMON_N + 1;
  localparam int DIVMON_MUW = DIVMON_MW + $clog2(MON_SCALE);
  // Scale by 80 folded into the reciprocal
  localparam logic [DIVMON_MUW-1:0] DIVMON_MUL =
    DIVMON_MUW'((((64'd1 << DIVMON_S) + MON_CYC - 1) / MON_CYC) * MON_SCALE);

  // Days in each month, indexed by month code; unused codes read as zero
  localparam jdc_day_t MONTH_DAYS [16] = '{
    5'd0,  5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
    5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0,  5'd0,  5'd0
  };

  // floor(367 * k / 12), k being the March-based month, indexed by month code
  localparam jdc_span_t MONTH_START [16] = '{
    9'd0,
    9'(MON_SPAN * 11 / 12), 9'(MON_SPAN * 12 / 12), 9'(MON_SPAN * 1 / 12),
    9'(MON_SPAN * 2 / 12),  9'(MON_SPAN * 3 / 12),  9'(MON_SPAN * 4 / 12),
    9'(MON_SPAN * 5 / 12),  9'(MON_SPAN * 6 / 12),  9'(MON_SPAN * 7 / 12),
    9'(MON_SPAN * 8 / 12),  9'(MON_SPAN * 9 / 12),  9'(MON_SPAN * 10 / 12),
    9'd0, 9'd0, 9'd0
  };

  // floor(2447 * j / 80)
  localparam jdc_span_t J_DAYS [16] = '{
    9'(MON_CYC * 0 / MON_SCALE),  9'(MON_CYC * 1 / MON_SCALE),
    9'(MON_CYC * 2 / MON_SCALE),  9'(MON_CYC * 3 / MON_SCALE),
    9'(MON_CYC * 4 / MON_SCALE),  9'(MON_CYC * 5 / MON_SCALE),
    9'(MON_CYC * 6 / MON_SCALE),  9'(MON_CYC * 7 / MON_SCALE),
    9'(MON_CYC * 8 / MON_SCALE),  9'(MON_CYC * 9 / MON_SCALE),
    9'(MON_CYC * 10 / MON_SCALE), 9'(MON_CYC * 11 / MON_SCALE),
    9'(MON_CYC * 12 / MON_SCALE), 9'(MON_CYC * 13 / MON_SCALE),
    9'(MON_CYC * 14 / MON_SCALE), 9'(MON_CYC * 15 / MON_SCALE)
  };

endpackage

@@ rtl/core/jdc_req_if.sv @@
// ----------------------------------------------------------------------------
// jdc_req_if
// Request channel: conversion direction, date and day number.
// ----------------------------------------------------------------------------
interface jdc_req_if;
  import jdc_pkg::*;

  logic       valid;
  logic       ready;
  logic       req_type;
  jdc_year_t  year_in;
  jdc_month_t month_in;
  jdc_day_t   day_in;
  jdc_jd_t    day_number_in;

  modport source (
    output valid, req_type, year_in, month_in, day_in, day_number_in,
    input  ready
  );

  modport sink (
    input  valid, req_type, year_in, month_in, day_in, day_number_in,
    output ready
  );

endinterface

@@ rtl/core/jdc_rsp_if.sv @@
// ----------------------------------------------------------------------------
// jdc_rsp_if
// Response channel: day number or date, and the invalid-date flag.
// ----------------------------------------------------------------------------
interface jdc_rsp_if;
  import jdc_pkg::*;

  logic       valid;
  logic       ready;
  jdc_jd_t    day_number_out;
  jdc_year_t  year_out;
  jdc_month_t month_out;
  jdc_day_t   day_out;
  logic       date_invalid;

  modport source (
    output valid, day_number_out, year_out, month_out, day_out, date_invalid,
    input  ready
  );

  modport sink (
    input  valid, day_number_out, year_out, month_out, day_out, date_invalid,
    output ready
  );

endinterface

@@ rtl/core/jdc_pipe_ctrl.sv @@
// ----------------------------------------------------------------------------
// jdc_pipe_ctrl
// Stage valid bits, per-stage load enables and the direction tag.
// ----------------------------------------------------------------------------
module jdc_pipe_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_req_type_i,
  input  logic              out_ready_i,
  output jdc_pkg::jdc_ctl_t ctl_o
);
  import jdc_pkg::*;

  logic [NUM_STAGES-1:0] v_q, v_d;
  jdc_stage_en_t         en;
  jdc_req_e              tag_q [NUM_STAGES-1];

  // A stage loads when it is empty or its content moves on
  always_comb begin
    en[NUM_STAGES-1] = !v_q[NUM_STAGES-1] || out_ready_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_comb begin
    v_d[0] = en[0] ? in_valid_i : v_q[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      v_d[k] = en[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      tag_q[0] <= jdc_req_e'(in_req_type_i);
    end
    for (int k = 1; k < NUM_STAGES - 1; k++) begin
      if (en[k]) begin
        tag_q[k] <= tag_q[k-1];
      end
    end
  end

  assign ctl_o.en        = en;
  assign ctl_o.out_valid = v_q[NUM_STAGES-1];
  assign ctl_o.tag       = tag_q[NUM_STAGES-2];

  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && en[0]) |=> v_q[0])
    else $error("accepted transaction missing from first stage");

  for (genvar k = 1; k < NUM_STAGES; k++) begin : g_chk_move
    a_item_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (v_q[k-1] && en[k]) |=> v_q[k])
      else $error("transaction lost between stages");
  end

  for (genvar k = 0; k < NUM_STAGES - 1; k++) begin : g_chk_hold
    a_item_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (v_q[k] && !en[k]) |=> v_q[k])
      else $error("stalled stage dropped its transaction");
  end

endmodule

@@ rtl/core/jdc_to_day.sv @@
// ----------------------------------------------------------------------------
// jdc_to_day
// Date check and Gregorian date to Julian day number, stages 0 to 4.
// ----------------------------------------------------------------------------
module jdc_to_day (
  input  logic                   clk_i,
  input  jdc_pkg::jdc_stage_en_t en_i,
  input  jdc_pkg::jdc_year_t     year_i,
  input  jdc_pkg::jdc_month_t    month_i,
  input  jdc_pkg::jdc_day_t      day_i,
  output jdc_pkg::jdc_day_res_t  res_o
);
  import jdc_pkg::*;

  localparam int D100_PW = DIV100_N + DIV100_MW;

  // stage 0
  logic signed [16:0]      ys, xs;
  logic                    a_neg;
  logic signed [15:0]      ybig_q;
  logic [DIV100_N-1:0]     absx_d, absx_q, absy_d, absy_q;
  logic                    negx_q;
  jdc_span_t               tm_q;
  jdc_day_t                day_q;
  logic                    ok_d, ok_q, feb29_q, y4_q;
  // stage 1
  logic [D100_PW-1:0]      prodx, prody;
  logic signed [26:0]      p_q;
  logic [7:0]              qx_q, qy_q;
  logic [DIV100_N-1:0]     absy1_q;
  logic                    negx1_q, ok1_q, feb29_1_q, y4_1_q;
  jdc_span_t               tm1_q;
  jdc_day_t                day1_q;
  // stage 2
  logic [9:0]              b3;
  logic [DIV100_N-1:0]     rem;
  logic                    leap;
  logic signed [24:0]      a_q;
  logic [7:0]              bmag_q;
  logic                    negx2_q, valid2_q;
  jdc_span_t               tm2_q;
  jdc_day_t                day2_q;
  // stage 3, 4
  logic [25:0]             jd;
  jdc_jd_t                 jd3_q, jd4_q;
  logic                    inv3_q, inv4_q;

  always_comb begin
    ys     = 17'(year_i);
    a_neg  = (month_i <= 4'd2);
    xs     = ys + 17'sd4900 - 17'(a_neg);
    absx_d = DIV100_N'(xs[16] ? -xs : xs);
    absy_d = DIV100_N'(year_i[YEAR_W-1] ? -ys : ys);
    ok_d   = (month_i inside {[4'd1:4'd12]}) && (day_i != '0) &&
             (day_i <= MONTH_DAYS[month_i]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      ybig_q  <= 16'(ys + 17'sd4800 - 17'(a_neg));
      absx_q  <= absx_d;
      negx_q  <= xs[16];
      absy_q  <= absy_d;
      tm_q    <= MONTH_START[month_i];
      day_q   <= day_i;
      ok_q    <= ok_d;
      feb29_q <= (month_i == 4'd2) && (day_i == 5'd29);
      y4_q    <= (year_i[1:0] == 2'b00);
    end
  end

  always_comb begin
    prodx = D100_PW'(absx_q) * D100_PW'(DIV100_M);
    prody = D100_PW'(absy_q) * D100_PW'(DIV100_M);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      p_q       <= 27'(ybig_q) * 27'sd1461;
      qx_q      <= prodx[DIV100_S +: 8];
      qy_q      <= prody[DIV100_S +: 8];
      absy1_q   <= absy_q;
      negx1_q   <= negx_q;
      ok1_q     <= ok_q;
      feb29_1_q <= feb29_q;
      y4_1_q    <= y4_q;
      tm1_q     <= tm_q;
      day1_q    <= day_q;
    end
  end

  // Leap: divisible by 4, and not by 100 unless by 400
  always_comb begin
    b3   = 10'(qx_q) + {1'b0, qx_q, 1'b0};
    rem  = absy1_q - DIV100_N'(DIV100_N'(qy_q) * DIV100_N'(CENT));
    leap = y4_1_q && ((rem != '0) || (qy_q[1:0] == 2'b00));
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      // truncate toward zero
      a_q      <= 25'((p_q + (p_q[26] ? 27'sd3 : 27'sd0)) >>> 2);
      bmag_q   <= b3[9:2];
      negx2_q  <= negx1_q;
      valid2_q <= ok1_q || (feb29_1_q && leap);
      tm2_q    <= tm1_q;
      day2_q   <= day1_q;
    end
  end

  always_comb begin
    jd = 26'(a_q) + 26'(tm2_q) + 26'(day2_q)
       + (negx2_q ? 26'(bmag_q) : -26'(bmag_q)) - 26'(JD_BIAS);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      jd3_q  <= valid2_q ? jd[JD_W-1:0] : '0;
      inv3_q <= !valid2_q;
    end
    if (en_i[4]) begin
      jd4_q  <= jd3_q;
      inv4_q <= inv3_q;
    end
  end

  assign res_o.day_number = jd4_q;
  assign res_o.invalid    = inv4_q;

endmodule

@@ rtl/core/jdc_to_date.sv @@
// ----------------------------------------------------------------------------
// jdc_to_date
// Julian day number to Gregorian year, month and day, stages 0 to 4 plus
// the month split that feeds the output register.
// ----------------------------------------------------------------------------
module jdc_to_date (
  input  logic                   clk_i,
  input  jdc_pkg::jdc_stage_en_t en_i,
  input  jdc_pkg::jdc_jd_t       day_number_i,
  output jdc_pkg::jdc_date_res_t res_o
);
  import jdc_pkg::*;

  localparam int ERA_PW = DIVERA_N + DIVERA_MW;
  localparam int CYC_PW = DIVCYC_N + DIVCYC_MW;
  localparam int MON_PW = SPAN_W + DIVMON_MUW;

  logic [23:0]        l1;
  logic [ERA_PW-1:0]  era_prod;
  logic [23:0]        l1_q;
  logic [7:0]         n_q, n1_q, n2_q, n3_q;
  logic [25:0]        era_days;
  logic [23:0]        l2w;
  logic [15:0]        l2_q, l2b_q, l2c_q;
  logic [DIVCYC_N-1:0] x3_q;
  logic [CYC_PW-1:0]  cyc_prod;
  logic [6:0]         i_q;
  logic [17:0]        quad;
  logic [16:0]        l3w;
  jdc_span_t          l3_q;
  logic [15:0]        ybase_q;
  logic [MON_PW-1:0]  mon_prod;
  logic [3:0]         j;
  logic               l4;

  always_comb begin
    l1       = 24'(day_number_i) + 24'(L_BIAS);
    era_prod = ERA_PW'({l1, 2'b00}) * ERA_PW'(DIVERA_M);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      l1_q <= l1;
      n_q  <= era_prod[DIVERA_S +: 8];
    end
  end

  always_comb begin
    era_days = 26'(n_q) * 26'(ERA_DAYS) + 26'd3;
    l2w      = l1_q - era_days[25:2];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      l2_q <= l2w[15:0];
      n1_q <= n_q;
    end
    if (en_i[2]) begin
      x3_q  <= (DIVCYC_N'(l2_q) + DIVCYC_N'(1)) * DIVCYC_N'(CENT_SCALE);
      l2b_q <= l2_q;
      n2_q  <= n1_q;
    end
  end

  always_comb begin
    cyc_prod = CYC_PW'(x3_q) * CYC_PW'(DIVCYC_M);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      i_q   <= cyc_prod[DIVCYC_S +: 7];
      l2c_q <= l2b_q;
      n3_q  <= n2_q;
    end
  end

  always_comb begin
    quad = 18'(i_q) * 18'(QUAD_DAYS);
    l3w  = 17'(l2c_q) - 17'(quad[17:2]) + 17'd31;
  end

  // Year base 100 * (n - 49) + i kept modulo 2**16
  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      l3_q    <= l3w[SPAN_W-1:0];
      ybase_q <= 16'(n3_q) * 16'(CENT) - 16'(Y_OFS_CENT) + 16'(i_q);
    end
  end

  // Split the March-based day into month and day; January and February
  // roll into the next year
  always_comb begin
    mon_prod = MON_PW'(l3_q) * MON_PW'(DIVMON_MUL);
    j        = mon_prod[DIVMON_S +: 4];
    l4       = (j >= 4'd11);
  end

  assign res_o.day   = DAY_W'(l3_q - J_DAYS[j]);
  assign res_o.month = j + 4'd2 - (l4 ? 4'd12 : 4'd0);
  assign res_o.year  = YEAR_W'(ybase_q + 16'(l4));

endmodule

@@ rtl/core/julian_day_converter.sv @@
// ----------------------------------------------------------------------------
// julian_day_converter
// Converts between proleptic Gregorian dates and Julian day numbers in
// both directions, with a date validity check on the way in.
//
//   channel   dir   handshake     payload
//   req_i     in    valid/ready   req_type, year_in, month_in, day_in,
//                                 day_number_in
//   rsp_o     out   valid/ready   day_number_out, year_out, month_out,
//                                 day_out, date_invalid
//
// One transaction per cycle while the output is not stalled; the result passes
// five stages plus the output register, a depth set by the chain
// of constant multiplications, about one per stage, in the day-number split.
// Reset clears the stage valid bits only.
// A stalled output holds; empty stages ahead of it keep taking new work.
// ----------------------------------------------------------------------------
module julian_day_converter (
  input  logic      clk_i,
  input  logic      rst_ni,
  jdc_req_if.sink   req_i,
  jdc_rsp_if.source rsp_o
);
  import jdc_pkg::*;

  jdc_ctl_t      ctl;
  jdc_day_res_t  day_res;
  jdc_date_res_t date_res;

  jdc_jd_t    jd_q;
  jdc_year_t  year_q;
  jdc_month_t month_q;
  jdc_day_t   day_q;
  logic       inv_q;

  jdc_pipe_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (req_i.valid),
    .in_req_type_i (req_i.req_type),
    .out_ready_i   (rsp_o.ready),
    .ctl_o         (ctl)
  );

  jdc_to_day u_to_day (
    .clk_i   (clk_i),
    .en_i    (ctl.en),
    .year_i  (req_i.year_in),
    .month_i (req_i.month_in),
    .day_i   (req_i.day_in),
    .res_o   (day_res)
  );

  jdc_to_date u_to_date (
    .clk_i        (clk_i),
    .en_i         (ctl.en),
    .day_number_i (req_i.day_number_in),
    .res_o        (date_res)
  );

  // Output register: zero the fields of the other direction
  always_ff @(posedge clk_i) begin
    if (ctl.en[NUM_STAGES-1]) begin
      if (ctl.tag == REQ_TO_DATE) begin
        jd_q    <= '0;
        inv_q   <= 1'b0;
        year_q  <= date_res.year;
        month_q <= date_res.month;
        day_q   <= date_res.day;
      end else begin
        jd_q    <= day_res.day_number;
        inv_q   <= day_res.invalid;
        year_q  <= '0;
        month_q <= '0;
        day_q   <= '0;
      end
    end
  end

  assign req_i.ready          = ctl.en[0];
  assign rsp_o.valid          = ctl.out_valid;
  assign rsp_o.day_number_out = jd_q;
  assign rsp_o.year_out       = year_q;
  assign rsp_o.month_out      = month_q;
  assign rsp_o.day_out        = day_q;
  assign rsp_o.date_invalid   = inv_q;

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.date_invalid) |->
      (rsp_o.day_number_out == '0) && (rsp_o.year_out == '0) &&
      (rsp_o.month_out == '0) && (rsp_o.day_out == '0))
    else $error("invalid date transaction carries nonzero fields");

endmodule
